// ----- rtl/gbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and constants for greedy box suppression
// Box and kept-list entry layouts, list depth and derived widths.
// ----------------------------------------------------------------------------
package gbs_pkg;

  // Depth of the kept list
  localparam int MAX_KEPT = 64;

  // Derived widths: address into the list, count up to MAX_KEPT inclusive
  localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W  = $clog2(MAX_KEPT + 1);

  // Field widths
  localparam int COORD_W      = 16;
  localparam int AREA_W       = 2 * COORD_W;
  localparam int UNION_W      = AREA_W + 1;
  localparam int THR_W        = 16;
  localparam int PROD_W       = THR_W + UNION_W;
  localparam int INDEX_W      = 16;
  localparam int KEPT_COUNT_W = 7;

  // Threshold after reset, about 0.45 in Q0.16
  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

  // Box geometry, Q12.4, x in the lowest bits
  typedef struct packed {
    logic [COORD_W-1:0] h;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } box_t;

  // One kept-list entry: box and its area, Q.8
  typedef struct packed {
    box_t              box;
    logic [AREA_W-1:0] area;
  } kept_entry_t;

  // Read return from the kept list to the overlap unit
  typedef struct packed {
    logic        valid;
    kept_entry_t entry;
  } kept_read_t;

endpackage

// ----- rtl/gbs_kept_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_kept_store: kept-box list memory
// One write port and one registered read port; contents undefined until written.
// ----------------------------------------------------------------------------
module gbs_kept_store
  import gbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  kept_entry_t       wr_entry,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output kept_read_t        rd
);

  kept_entry_t mem [MAX_KEPT];
  kept_entry_t rd_entry;
  logic        rd_valid;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // Registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

  // Read strobe is registered together with the data and marks when it is valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  assign rd.valid = rd_valid;
  assign rd.entry = rd_entry;

endmodule

// ----- rtl/gbs_overlap_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_overlap_unit: pipelined overlap test
// Tests the candidate against one kept entry per cycle:
// inter * 2^16 > threshold * union, without division.
// ----------------------------------------------------------------------------
module gbs_overlap_unit
  import gbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  kept_read_t        kept,
  input  box_t              cand,
  input  logic [AREA_W-1:0] cand_area,
  input  logic [THR_W-1:0]  threshold,
  output logic              hit,
  output logic              busy
);

  // Stage valids
  logic s1_valid, s2_valid, s3_valid, s4_valid;

  // Stage 1: overlap extents
  logic [COORD_W-1:0] s1_dw, s1_dh;
  logic [AREA_W-1:0]  s1_area;
  // Stage 2: intersection area
  logic [AREA_W-1:0]  s2_inter, s2_area;
  // Stage 3: union
  logic [AREA_W-1:0]  s3_inter;
  logic [UNION_W-1:0] s3_union;
  // Stage 4: both sides of the compare
  logic [AREA_W-1:0]  s4_inter;
  logic [PROD_W-1:0]  s4_prod;

  // Edge arithmetic for stage 1
  logic [COORD_W:0]   left, right, top, bottom;
  logic [COORD_W:0]   c_right, k_right, c_bottom, k_bottom;
  logic [COORD_W:0]   dw_full, dh_full;
  box_t               kb;

  always_comb begin
    kb       = kept.entry.box;
    c_right  = {1'b0, cand.x} + {1'b0, cand.w};
    k_right  = {1'b0, kb.x} + {1'b0, kb.w};
    c_bottom = {1'b0, cand.y} + {1'b0, cand.h};
    k_bottom = {1'b0, kb.y} + {1'b0, kb.h};
    left     = (cand.x > kb.x) ? {1'b0, cand.x} : {1'b0, kb.x};
    top      = (cand.y > kb.y) ? {1'b0, cand.y} : {1'b0, kb.y};
    right    = (c_right < k_right) ? c_right : k_right;
    bottom   = (c_bottom < k_bottom) ? c_bottom : k_bottom;
    // touching or disjoint boxes give no overlap
    dw_full  = (right > left) ? (right - left) : '0;
    dh_full  = (bottom > top) ? (bottom - top) : '0;
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= kept.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    // extents never exceed the narrower width, so the top bit is zero
    s1_dw    <= dw_full[COORD_W-1:0];
    s1_dh    <= dh_full[COORD_W-1:0];
    s1_area  <= kept.entry.area;

    s2_inter <= {{(AREA_W-COORD_W){1'b0}}, s1_dw} * {{(AREA_W-COORD_W){1'b0}}, s1_dh};
    s2_area  <= s1_area;

    s3_inter <= s2_inter;
    s3_union <= {1'b0, cand_area} + {1'b0, s2_area} - {1'b0, s2_inter};

    s4_inter <= s3_inter;
    s4_prod  <= {{(PROD_W-THR_W){1'b0}}, threshold} * {{(PROD_W-UNION_W){1'b0}}, s3_union};
  end

  // Final compare
  assign hit  = s4_valid && ({1'b0, s4_inter, 16'd0} > s4_prod);
  assign busy = kept.valid | s1_valid | s2_valid | s3_valid | s4_valid;

endmodule

// ----- rtl/greedy_box_suppression_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_suppression_core: greedy non-maximum suppression by IoU
// Sequencer, kept-list memory and a shared pipelined overlap test.
// ----------------------------------------------------------------------------
// Usage:
//   Boxes come in on the s_axis channel sorted by falling score; tuser set
//   on a box clears the kept list and restarts the frame position. Each box
//   gives one result on m_axis: keep flag, list-full flag, its index in the
//   frame and the number of stored boxes after it. The threshold is written
//   on the cfg channel by the user only while the block idles; unenforced.
// Sequence:
//   After a transfer the kept list is read one entry per cycle, then the
//   overlap unit drains its read register and four stages. The result is
//   then registered and s_axis_tready rises with it; a box that meets an
//   empty list skips the reads.
//   s_axis_tready is high only between boxes; the next box may be taken
//   while the previous result still waits in the output register.
// Reset:
//   rst clears the kept count, the frame position and the output valid and
//   loads the threshold with 0.45. A stalled receiver holds the result and
//   the next box waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module greedy_box_suppression_core
  import gbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // threshold write, Q0.16
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // candidate boxes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // box_x, box_y, box_width, box_height
  input  logic        s_axis_tuser,   // frame_start
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // box_index, kept_count, zero pad
  output logic [1:0]  m_axis_tuser    // keep, list_full
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]         state, state_next;
  logic [THR_W-1:0]   threshold;
  logic [CNT_W-1:0]   kept_total;
  logic [CNT_W-1:0]   scan_idx;
  logic [INDEX_W-1:0] frame_position;
  logic [INDEX_W-1:0] box_index;
  logic               suppress;
  box_t               cand;
  logic [AREA_W-1:0]  cand_area;

  logic               in_xfer;
  logic               out_free;
  logic               finish;
  logic               keep_now;
  logic               room;
  logic               rd_en;
  logic               wr_en;
  logic               hit;
  logic               busy;
  logic [INDEX_W-1:0] pos_cur;
  logic [CNT_W-1:0]   count_next;
  kept_entry_t        wr_entry;
  kept_read_t         kept_rd;

  // Output register
  logic                    out_valid;
  logic                    out_keep;
  logic                    out_full;
  logic [INDEX_W-1:0]      out_index;
  logic [KEPT_COUNT_W-1:0] out_count;

  // Handshakes
  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign finish        = (state == ST_DONE) && out_free;

  // Decision for the current box
  assign keep_now   = !suppress;
  assign room       = (kept_total < CNT_W'(MAX_KEPT));
  assign wr_en      = finish && keep_now && room;
  assign count_next = wr_en ? (kept_total + CNT_W'(1)) : kept_total;
  assign rd_en      = (state == ST_SCAN) && (scan_idx < kept_total);
  assign pos_cur    = s_axis_tuser ? '0 : frame_position;

  assign wr_entry.box  = cand;
  assign wr_entry.area = cand_area;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_idx >= kept_total) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!busy) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      kept_total     <= '0;
      frame_position <= '0;
      scan_idx       <= '0;
      suppress       <= 1'b0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        scan_idx <= '0;
        suppress <= 1'b0;
        if (s_axis_tuser) kept_total <= '0;
        // saturating frame position
        frame_position <= (pos_cur == '1) ? pos_cur : pos_cur + INDEX_W'(1);
      end else begin
        if (rd_en) scan_idx <= scan_idx + CNT_W'(1);
        if (hit) suppress <= 1'b1;
        if (finish) kept_total <= count_next;
      end
    end
  end

  // Candidate registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cand      <= s_axis_tdata;
      box_index <= pos_cur;
    end
    cand_area <= {{(AREA_W-COORD_W){1'b0}}, cand.w} * {{(AREA_W-COORD_W){1'b0}}, cand.h};
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_keep  <= keep_now;
      out_full  <= keep_now && !room;
      out_index <= box_index;
      out_count <= KEPT_COUNT_W'(count_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_count, out_index};
  assign m_axis_tuser  = {out_full, out_keep};

  // Kept list
  gbs_kept_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (kept_total[ADDR_W-1:0]),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (scan_idx[ADDR_W-1:0]),
    .rd       (kept_rd)
  );

  // Overlap test
  gbs_overlap_unit u_overlap (
    .clk       (clk),
    .rst       (rst),
    .kept      (kept_rd),
    .cand      (cand),
    .cand_area (cand_area),
    .threshold (threshold),
    .hit       (hit),
    .busy      (busy)
  );

endmodule

// ----- tb/suppression_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suppression_checker: verdict predictor and comparator for box suppression
// Watches the threshold, box and result channels. Each accepted box is judged
// against a private kept list. Each result is compared with the oldest
// pending verdict. The running error count goes to the top.
// ----------------------------------------------------------------------------
module suppression_checker
  import gbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // box_x, box_y, box_width, box_height
  input  logic        s_axis_tuser,   // frame_start
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // box_index, kept_count, zero pad
  input  logic [1:0]  m_axis_tuser,   // keep, list_full
  output int          mismatches,
  output int          awaiting
);

  typedef struct packed {
    logic                    keep;
    logic                    full;
    logic [INDEX_W-1:0]      idx;
    logic [KEPT_COUNT_W-1:0] count;
  } verdict_t;

  box_t              kept_box  [MAX_KEPT];
  logic [AREA_W-1:0] kept_area [MAX_KEPT];
  int                kept_n    = 0;
  int                frame_pos = 0;
  logic [THR_W-1:0]  thr       = THR_RESET;
  verdict_t          verdict_q [$];
  int                err_n     = 0;

  // overlap area of two boxes; edge sums need the 17th bit
  function automatic logic [63:0] overlap_area(input box_t p, input box_t q);
    logic [16:0] lo_x, lo_y, hi_x, hi_y, p_end, q_end;
    lo_x  = (p.x > q.x) ? {1'b0, p.x} : {1'b0, q.x};
    lo_y  = (p.y > q.y) ? {1'b0, p.y} : {1'b0, q.y};
    p_end = {1'b0, p.x} + {1'b0, p.w};
    q_end = {1'b0, q.x} + {1'b0, q.w};
    hi_x  = (p_end < q_end) ? p_end : q_end;
    p_end = {1'b0, p.y} + {1'b0, p.h};
    q_end = {1'b0, q.y} + {1'b0, q.h};
    hi_y  = (p_end < q_end) ? p_end : q_end;
    // disjoint or touching boxes share no area
    if (hi_x <= lo_x || hi_y <= lo_y) return '0;
    return 64'(hi_x - lo_x) * 64'(hi_y - lo_y);
  endfunction

  // judge one box against the kept list and queue its verdict
  task automatic judge_box(input logic fs, input box_t b);
    logic [63:0] cand_area, inter, uni;
    verdict_t    v;
    if (fs) begin
      kept_n    = 0;
      frame_pos = 0;
    end
    cand_area = 64'(b.w) * 64'(b.h);
    v.idx     = frame_pos[INDEX_W-1:0];
    if (frame_pos < 65535) frame_pos++;
    // division-free test: inter * 2^16 > thr * union
    v.keep = 1'b1;
    for (int j = 0; j < kept_n; j++) begin
      inter = overlap_area(b, kept_box[j]);
      uni   = cand_area + 64'(kept_area[j]) - inter;
      if ((inter << 16) > 64'(thr) * uni) v.keep = 1'b0;
    end
    // survivors are stored while there is room, otherwise flagged
    v.full = 1'b0;
    if (v.keep) begin
      if (kept_n < MAX_KEPT) begin
        kept_box[kept_n]  = b;
        kept_area[kept_n] = cand_area[AREA_W-1:0];
        kept_n++;
      end else begin
        v.full = 1'b1;
      end
    end
    v.count   = kept_n[KEPT_COUNT_W-1:0];
    verdict_q = {verdict_q, v};
  endtask

  task automatic flag(input string field, input int exp_v, input int act_v);
    err_n++;
    $error("%s: expected %0d, got %0d", field, exp_v, act_v);
  endtask

  // results are retired before new boxes are judged in the same cycle
  always @(posedge clk) begin
    verdict_t want, got;
    if (rst) begin
      kept_n    = 0;
      frame_pos = 0;
      thr       = THR_RESET;
      verdict_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.keep  = m_axis_tuser[0];
        got.full  = m_axis_tuser[1];
        got.idx   = m_axis_tdata[15:0];
        got.count = m_axis_tdata[22:16];
        if (verdict_q.size() == 0) begin
          err_n++;
          $error("result with no box pending, box_index %0d", got.idx);
        end else begin
          want = verdict_q.pop_front();
          if (got.keep !== want.keep)
            flag("keep", int'(want.keep), int'(got.keep));
          if (got.idx !== want.idx)
            flag("box_index", int'(want.idx), int'(got.idx));
          if (got.count !== want.count)
            flag("kept_count", int'(want.count), int'(got.count));
          if (got.full !== want.full)
            flag("list_full", int'(want.full), int'(got.full));
        end
      end
      if (s_axis_tvalid && s_axis_tready) judge_box(s_axis_tuser, box_t'(s_axis_tdata));
      if (cfg_valid && cfg_ready) thr = cfg_data;
    end
    mismatches <= err_n;
    awaiting   <= verdict_q.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for greedy_box_suppression_core
// Directed boxes for edge geometry, then random frames (clustered, tiled
// and stray boxes) under several thresholds and idling patterns.
// ----------------------------------------------------------------------------
module tb
  import gbs_pkg::*;
();

  localparam int STALL_LIMIT     = 4000;
  localparam int TAIL_CYCLES     = 100;
  localparam int ITEMS_PER_PHASE = 250;

  logic             clk           = 1'b0;
  logic             rst           = 1'b1;
  logic             cfg_valid     = 1'b0;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data      = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [63:0]      s_axis_tdata  = '0;   // box_x, box_y, box_width, box_height
  logic             s_axis_tuser  = 1'b0; // frame_start
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;         // box_index, kept_count, zero pad
  logic [1:0]       m_axis_tuser;         // keep, list_full
  int               mismatches;
  int               awaiting;
  int               gap_pct       = 0;
  int               stall_pct     = 0;
  int               quiet         = 0;

  greedy_box_suppression_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  suppression_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .awaiting      (awaiting)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet + 1 >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic box_t box_at(input int x, input int y, input int w, input int h);
    box_t b;
    b.x = x[15:0];
    b.y = y[15:0];
    b.w = w[15:0];
    b.h = h[15:0];
    return b;
  endfunction

  // one box transfer; tvalid stays high on return so back-to-back boxes never
  // see it dropped and raised in the same step
  task automatic send_box(input logic fs, input box_t b);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= fs;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // stop sending and wait until every result has come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random frames until about target boxes have been sent
  task automatic run_frames(input int target);
    int   done, n, kind, ox, oy, bx, by, spread;
    box_t b, prev;
    box_t tiles [72];
    done = 0;
    prev = '0;
    while (done < target) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        // tiled frame: disjoint boxes fill the list, late repeats hit stored ones
        n  = $urandom_range(72, 66);
        ox = $urandom_range(60000);
        oy = $urandom_range(61000);
        for (int k = 0; k < n; k++) begin
          tiles[k] = box_at(ox + (k % 9) * 512 + $urandom_range(100),
                            oy + (k / 9) * 512 + $urandom_range(100),
                            $urandom_range(400), $urandom_range(400));
          b = (k >= 64 && $urandom_range(3) == 0) ? tiles[$urandom_range(63)] : tiles[k];
          send_box(k == 0, b);
        end
      end else if (kind < 80) begin
        // clustered frame: nearby boxes and repeats, so overlaps are common
        n      = $urandom_range(30, 1);
        spread = 16 << (2 * $urandom_range(3));
        bx     = $urandom_range(65535 - 4 * spread);
        by     = $urandom_range(65535 - 4 * spread);
        for (int k = 0; k < n; k++) begin
          if (k > 0 && $urandom_range(99) < 15) begin
            b = prev;
          end else begin
            b = box_at(bx + $urandom_range(spread), by + $urandom_range(spread),
                       $urandom_range(2 * spread), $urandom_range(2 * spread));
          end
          send_box(k == 0, b);
          prev = b;
        end
      end else begin
        // stray boxes: any field value, frame start at random
        n = $urandom_range(4, 1);
        for (int k = 0; k < n; k++) begin
          send_box(1'($urandom_range(1)), box_at($urandom, $urandom, $urandom, $urandom));
        end
      end
      done += n;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed boxes at the reset threshold
    send_box(1'b1, box_at(0, 0, 0, 0));
    send_box(1'b0, box_at(0, 0, 0, 0));          // zero union: kept
    send_box(1'b1, box_at(100, 100, 160, 160));
    send_box(1'b0, box_at(100, 100, 160, 160));  // identical: suppressed
    send_box(1'b0, box_at(260, 100, 160, 160));  // touching edge
    send_box(1'b0, box_at(160, 100, 160, 160));  // IoU just above 0.45
    send_box(1'b0, box_at(161, 100, 160, 160));  // IoU just below 0.45
    send_box(1'b0, box_at(5000, 5000, 32, 32));  // disjoint
    send_box(1'b0, box_at(500, 500, 0, 4000));   // zero width
    send_box(1'b1, box_at(65535, 65535, 65535, 65535));
    send_box(1'b0, box_at(0, 0, 65535, 65535));
    send_box(1'b0, box_at(0, 0, 65535, 65535));
    send_box(1'b0, box_at(65535, 0, 65535, 65535));
    send_box(1'b0, box_at(32768, 32768, 32767, 32767));
    send_box(1'b0, box_at(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
    send_box(1'b0, box_at(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555));

    // random phases: threshold and idling change only while idle
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
          set_threshold(16'd0);
        end
        1: begin
          gap_pct   = 64;
          stall_pct = 0;
          set_threshold(16'd65535);
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 64;
          set_threshold(16'($urandom_range(65535)));
        end
        default: begin
          gap_pct   = 32;
          stall_pct = 32;
          set_threshold(16'($urandom_range(65535)));
        end
      endcase
      run_frames(ITEMS_PER_PHASE);
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
